>>> design/slpg_pkg.sv
package slpg_pkg;

    localparam int HOLD_WIDTH_DEF = 16;
    localparam int TIMEOUT_W      = 16;
    localparam int PHASE_W        = 10;
    localparam int BIND_W         = 3;
    localparam int CFG_IDX_W      = 1;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(999);

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_USE_RADIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

    localparam logic [BIND_W-1:0] BIND_NONE        = 3'd0;
    localparam logic [BIND_W-1:0] BIND_SEARCHING   = 3'd1;
    localparam logic [BIND_W-1:0] BIND_NEGOTIATING = 3'd2;
    localparam logic [BIND_W-1:0] BIND_SUCCESS     = 3'd3;
    localparam logic [BIND_W-1:0] BIND_FAILURE     = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam t_rgb RGB_OFF    = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam t_rgb RGB_WHITE  = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    localparam t_rgb RGB_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
    localparam t_rgb RGB_BLUE   = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
    localparam t_rgb RGB_YELLOW = '{red: 8'd200, green: 8'd200, blue: 8'd0};
    localparam t_rgb RGB_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0};

endpackage

>>> design/slpg_hold.sv
module slpg_hold
    import slpg_pkg::*;
#(
    parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_load,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    output logic                 o_active
);

    localparam int EXT_W = (HOLD_WIDTH > TIMEOUT_W) ? HOLD_WIDTH : TIMEOUT_W;
    localparam logic [EXT_W-1:0] HOLD_MAX_EXT = EXT_W'({HOLD_WIDTH{1'b1}});

    logic [HOLD_WIDTH-1:0] r_hold;
    logic [HOLD_WIDTH-1:0] n_hold;
    logic [EXT_W-1:0]      timeout_ext;
    logic [HOLD_WIDTH-1:0] load_val;
    logic [HOLD_WIDTH-1:0] eff_hold;

    assign timeout_ext = EXT_W'(i_timeout);
    assign load_val    = (timeout_ext > HOLD_MAX_EXT) ? {HOLD_WIDTH{1'b1}}
                                                      : HOLD_WIDTH'(timeout_ext);
    assign eff_hold    = i_load ? load_val : r_hold;
    assign o_active    = (eff_hold != '0);

    always_comb begin
        n_hold = r_hold;
        if (i_step) begin
            n_hold = o_active ? eff_hold - HOLD_WIDTH'(1) : eff_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else begin
            r_hold <= n_hold;
        end
    end

    a_no_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> r_hold == $past(r_hold))
        else $error("hold counter moved without a tick");

endmodule

>>> design/slpg_color.sv
module slpg_color
    import slpg_pkg::*;
(
    input  logic [BIND_W-1:0]  i_bind,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic               i_active,
    output t_rgb               o_color
);

    logic search_on;
    logic negot_on;
    logic fail_on;

    assign search_on = (i_phase < 10'd250);
    assign negot_on  = (i_phase < 10'd125)
                    || (i_phase >= 10'd250 && i_phase < 10'd375)
                    || (i_phase >= 10'd500 && i_phase < 10'd625)
                    || (i_phase >= 10'd750 && i_phase < 10'd875);
    assign fail_on   = (i_phase < 10'd150)
                    || (i_phase >= 10'd300 && i_phase < 10'd450)
                    || (i_phase >= 10'd600 && i_phase < 10'd750);

    always_comb begin
        unique case (i_bind)
            BIND_NONE:        o_color = i_active ? RGB_WHITE : RGB_RED;
            BIND_SEARCHING:   o_color = search_on ? RGB_BLUE : RGB_OFF;
            BIND_NEGOTIATING: o_color = negot_on ? RGB_YELLOW : RGB_OFF;
            BIND_SUCCESS:     o_color = RGB_GREEN;
            BIND_FAILURE:     o_color = fail_on ? RGB_RED : RGB_OFF;
            default:          o_color = RGB_OFF;
        endcase
    end

endmodule

>>> design/status_led_pattern_generator.sv
// Status LED pattern generator. Each input transfer is one millisecond tick
// carrying the serial and radio receive flags and the binding state; an output
// transfer carries the new LED colour and appears only when the colour changes.
// One tick is taken every clock cycle while the input side is not stalled; a
// tick lands in the input register, its colour is worked out from there and, on
// a change, written to the output register when the tick advances.
// The input side stalls only while a colour change finds the output register
// still full and not being taken.
module status_led_pattern_generator
    import slpg_pkg::*;
#(
    parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIMEOUT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] serial_rx_seen, [1] radio_rx_seen, [4:2] binding_state, [7:5] zero
    input  logic [7:0]           s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [23:0]          m_axis_tdata
);

    logic                 r_use_radio;
    logic [TIMEOUT_W-1:0] r_timeout;

    logic              r_in_valid;
    logic              r_in_serial;
    logic              r_in_radio;
    logic [BIND_W-1:0] r_in_bind;

    logic [PHASE_W-1:0] r_phase;
    t_rgb               r_shown;
    logic               r_out_valid;
    t_rgb               r_out;

    logic serial_active;
    logic radio_active;
    t_rgb color;
    logic change;
    logic advance;
    logic in_xfer;

    assign change  = (color != r_shown);
    assign advance = r_in_valid && (!change || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_radio <= 1'b0;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_USE_RADIO: r_use_radio <= i_cfg_data[0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_serial <= s_axis_tdata[0];
            r_in_radio  <= s_axis_tdata[1];
            r_in_bind   <= s_axis_tdata[4:2];
        end
    end

    slpg_hold #(.HOLD_WIDTH(HOLD_WIDTH)) u_serial_hold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_load    (r_in_serial),
        .i_timeout (r_timeout),
        .o_active  (serial_active)
    );

    slpg_hold #(.HOLD_WIDTH(HOLD_WIDTH)) u_radio_hold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_load    (r_in_radio),
        .i_timeout (r_timeout),
        .o_active  (radio_active)
    );

    slpg_color u_color (
        .i_bind   (r_in_bind),
        .i_phase  (r_phase),
        .i_active (r_use_radio ? radio_active : serial_active),
        .o_color  (color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_shown     <= RGB_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (advance && change) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_phase <= (r_phase == PHASE_LAST) ? '0 : r_phase + PHASE_W'(1);
                if (change) begin
                    r_shown <= color;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && change) begin
            r_out <= color;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.blue, r_out.green, r_out.red};

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_LAST)
        else $error("phase left its range");

    a_pending_is_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out == r_shown)
        else $error("pending colour differs from shown colour");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && change && r_out_valid)
        else $error("input stalled without a blocked colour change");

endmodule

>>> sim/status_led_pattern_generator_test.sv
module status_led_pattern_generator_test;
    import slpg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PHASE_TICKS   = 225;
    localparam int unsigned HOLD_OFF_LEN  = 300;
    localparam int unsigned SETTLE_CYCLES = 6;

    localparam logic [BIND_W-1:0] BIND_BAD_LO  = 3'd5;
    localparam logic [BIND_W-1:0] BIND_BAD_MID = 3'd6;
    localparam logic [BIND_W-1:0] BIND_BAD_HI  = 3'd7;

    typedef struct packed {
        bit                serial;
        bit                radio;
        logic [BIND_W-1:0] bind_state;
        bit                typed;
        bit                has_result;
        t_rgb              want;
    } t_tick_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_USE_RADIO;
    logic [TIMEOUT_W-1:0] i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;

    // colour model state
    bit                   use_radio   = 1'b0;
    logic [TIMEOUT_W-1:0] timeout_ms  = TIMEOUT_RST;
    logic [PHASE_W-1:0]   phase_ms    = '0;
    logic [15:0]          serial_hold = '0;
    logic [15:0]          radio_hold  = '0;
    t_rgb                 shown       = RGB_OFF;

    t_rgb        expected_colours[$];
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    bit          steady_flow   = 1'b0;
    int unsigned hold_off_asks = 0;
    int unsigned hold_off_seen = 0;
    int unsigned stall_left    = 0;

    bit                   use_radio_plan [PHASE_COUNT] = '{1, 0, 1, 0, 1, 0, 1, 0};
    logic [TIMEOUT_W-1:0] timeout_plan   [PHASE_COUNT] =
        '{16'd1, 16'd0, 16'd65535, 16'd5, 16'd12, 16'd3, 16'd0, 16'd1000};

    t_tick_row directed_ticks [20] = '{
        '{1'b0, 1'b0, BIND_NONE,        1'b1, 1'b1, RGB_RED},
        '{1'b1, 1'b0, BIND_NONE,        1'b1, 1'b1, RGB_WHITE},
        '{1'b0, 1'b0, BIND_SEARCHING,   1'b1, 1'b1, RGB_BLUE},
        '{1'b0, 1'b0, BIND_NEGOTIATING, 1'b1, 1'b1, RGB_YELLOW},
        '{1'b0, 1'b0, BIND_SUCCESS,     1'b1, 1'b1, RGB_GREEN},
        '{1'b0, 1'b0, BIND_FAILURE,     1'b1, 1'b1, RGB_RED},
        '{1'b0, 1'b0, BIND_BAD_LO,      1'b1, 1'b1, RGB_OFF},
        '{1'b0, 1'b0, BIND_BAD_MID,     1'b1, 1'b0, RGB_OFF},
        '{1'b1, 1'b1, BIND_BAD_HI,      1'b1, 1'b0, RGB_OFF},
        '{1'b0, 1'b0, BIND_NONE,        1'b1, 1'b1, RGB_WHITE},
        '{1'b0, 1'b1, BIND_NONE,        1'b1, 1'b0, RGB_OFF},
        '{1'b0, 1'b0, BIND_SUCCESS,     1'b1, 1'b1, RGB_GREEN},
        '{1'b0, 1'b0, BIND_SUCCESS,     1'b1, 1'b0, RGB_OFF},
        '{1'b1, 1'b1, BIND_FAILURE,     1'b1, 1'b1, RGB_RED},
        '{1'b0, 1'b0, BIND_SEARCHING,   1'b1, 1'b1, RGB_BLUE},
        '{1'b0, 1'b0, BIND_NEGOTIATING, 1'b0, 1'b0, RGB_OFF},
        '{1'b1, 1'b0, BIND_SEARCHING,   1'b0, 1'b0, RGB_OFF},
        '{1'b0, 1'b1, BIND_NONE,        1'b0, 1'b0, RGB_OFF},
        '{1'b0, 1'b0, BIND_FAILURE,     1'b0, 1'b0, RGB_OFF},
        '{1'b1, 1'b1, BIND_NONE,        1'b0, 1'b0, RGB_OFF}
    };

    status_led_pattern_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status_led_pattern_generator_test: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_asks != hold_off_seen) begin
            hold_off_seen <= hold_off_asks;
            stall_left    <= HOLD_OFF_LEN;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady_flow || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_colours.size() == 0) begin
                $error("unexpected colour transfer %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_colours.pop_front();
                if (m_axis_tdata[7:0] !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:8] !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, m_axis_tdata[15:8]);
                    mismatches++;
                end
                if (m_axis_tdata[23:16] !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, m_axis_tdata[23:16]);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_rgb led_colour(input logic [BIND_W-1:0] bind_state);
        int unsigned p;
        bit          link_up;
        p = phase_ms;
        link_up = use_radio ? (radio_hold != 0) : (serial_hold != 0);
        case (bind_state)
            BIND_NONE:        return link_up ? RGB_WHITE : RGB_RED;
            BIND_SEARCHING:   return (p < 250) ? RGB_BLUE : RGB_OFF;
            BIND_NEGOTIATING: return ((p % 250) < 125) ? RGB_YELLOW : RGB_OFF;
            BIND_SUCCESS:     return RGB_GREEN;
            BIND_FAILURE: begin
                if (p < 150 || (p >= 300 && p < 450) || (p >= 600 && p < 750))
                    return RGB_RED;
                return RGB_OFF;
            end
            default:          return RGB_OFF;
        endcase
    endfunction

    // advance the tick model; returns 1 when the colour changes
    function automatic bit tick_led_model(input bit serial, input bit radio,
                                          input logic [BIND_W-1:0] bind_state,
                                          output t_rgb colour);
        bit changed;
        if (serial)
            serial_hold = timeout_ms;
        if (radio)
            radio_hold = timeout_ms;
        colour  = led_colour(bind_state);
        changed = (colour != shown);
        shown   = colour;
        phase_ms = (phase_ms == PHASE_LAST) ? '0 : phase_ms + 1'b1;
        if (serial_hold != 0)
            serial_hold--;
        if (radio_hold != 0)
            radio_hold--;
        return changed;
    endfunction

    task automatic send_tick(input bit serial, input bit radio,
                             input logic [BIND_W-1:0] bind_state,
                             input bit typed = 1'b0, input bit typed_result = 1'b0,
                             input t_rgb typed_colour = RGB_OFF);
        t_rgb colour;
        bit   changed;
        while (!steady_flow && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, bind_state, radio, serial};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        changed = tick_led_model(serial, radio, bind_state, colour);
        if (typed ? typed_result : changed)
            expected_colours.push_back(typed ? typed_colour : colour);
    endtask

    task automatic drain_colours();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_colours.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [TIMEOUT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_USE_RADIO)
            use_radio = value[0];
        else
            timeout_ms = value;
    endtask

    function automatic bit rx_draw(input int unsigned odds);
        return (odds != 0) && ($urandom_range(odds - 1) == 0);
    endfunction

    function automatic int unsigned pick_rx_odds();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 20;
            default: return 200;
        endcase
    endfunction

    task automatic run_random_ticks(input int unsigned count, input bit short_runs,
                                    input int unsigned pause_at);
        int unsigned       sent;
        int unsigned       run_len;
        int unsigned       serial_odds;
        int unsigned       radio_odds;
        logic [BIND_W-1:0] bind_state;
        sent = 0;
        while (sent < count) begin
            run_len = (short_runs || $urandom_range(4) == 0) ? $urandom_range(1, 4)
                                                             : $urandom_range(1, 300);
            if ($urandom_range(99) < 12)
                bind_state = BIND_W'($urandom_range(BIND_BAD_LO, BIND_BAD_HI));
            else
                bind_state = BIND_W'($urandom_range(BIND_NONE, BIND_FAILURE));
            serial_odds = pick_rx_odds();
            radio_odds  = pick_rx_odds();
            repeat (run_len) begin
                if (sent < count) begin
                    if (sent == pause_at)
                        drain_colours();
                    send_tick(rx_draw(serial_odds), rx_draw(radio_odds), bind_state);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ticks[k])
            send_tick(directed_ticks[k].serial, directed_ticks[k].radio,
                      directed_ticks[k].bind_state, directed_ticks[k].typed,
                      directed_ticks[k].has_result, directed_ticks[k].want);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_colours();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_reg(CFG_USE_RADIO, {TIMEOUT_W'($urandom) & 16'hFFFE} | use_radio_plan[ph]);
            write_reg(CFG_TIMEOUT, timeout_plan[ph]);
            i_cfg_we    <= 1'b0;
            steady_flow <= (ph == 2);
            // stall the output while short runs keep the colour changing
            if (ph == 4)
                hold_off_asks <= hold_off_asks + 1;
            run_random_ticks(PHASE_TICKS, ph == 4, (ph == 5) ? 100 : PHASE_TICKS);
        end

        drain_colours();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status_led_pattern_generator_test: PASS");
        else
            $display("status_led_pattern_generator_test: FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/slpg_pkg.sv
design/slpg_hold.sv
design/slpg_color.sv
design/status_led_pattern_generator.sv
sim/status_led_pattern_generator_test.sv
